>>> rtl/deque_with_reverse_and_middle_unit_defines.svh
// assertion macros for the deque rtl
`ifndef DEQUE_WITH_REVERSE_AND_MIDDLE_UNIT_DEFINES_SVH
`define DEQUE_WITH_REVERSE_AND_MIDDLE_UNIT_DEFINES_SVH

// property that must hold in the same cycle as its trigger
`define DEQR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// property that must hold in the cycle after its trigger
`define DEQR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/deqr_pkg.sv
// shared constants, operation and status codes and result metadata for the deque
package deqr_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int DATA_W    = 32;
    localparam int KIND_W    = 3;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 6;

    // operation codes
    localparam logic [KIND_W-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [KIND_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [KIND_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [KIND_W-1:0] OP_REVERSE    = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // per-transaction info carried from the control stage to the result stage
    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic                     pop;
        logic [COUNT_W-1:0]       count;
        logic                     none_left;
        logic                     odd;
        logic                     byp_ml;
        logic                     byp_mr;
        logic signed [DATA_W-1:0] wdata;
    } meta_t;

endpackage

>>> rtl/deqr_ram.sv
// word storage with one write port and one registered read port
module deqr_ram #(
    parameter int DEPTH = deqr_pkg::DEPTH_DEF,
    parameter int AW    = 5
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [AW-1:0]                     waddr,
    input  logic signed [deqr_pkg::DATA_W-1:0] wdata,
    input  logic                              re,
    input  logic [AW-1:0]                     raddr,
    output logic signed [deqr_pkg::DATA_W-1:0] rdata
);

    logic signed [deqr_pkg::DATA_W-1:0] mem [DEPTH];
    logic signed [deqr_pkg::DATA_W-1:0] rdata_reg;

    // write and registered read, read returns the old word on a collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/deqr_ctrl.sv
// pointer state, operation decode and slot address generation for the deque
`include "deque_with_reverse_and_middle_unit_defines.svh"

module deqr_ctrl #(
    parameter int DEPTH = deqr_pkg::DEPTH_DEF,
    parameter int AW    = 5,
    parameter int CW    = 6
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               accept,
    input  logic [deqr_pkg::KIND_W-1:0]        kind,
    input  logic signed [deqr_pkg::DATA_W-1:0] data,
    output logic                               we,
    output logic [AW-1:0]                      waddr,
    output logic [AW-1:0]                      raddr_pop,
    output logic [AW-1:0]                      raddr_ml,
    output logic [AW-1:0]                      raddr_mr,
    output deqr_pkg::meta_t                    meta
);

    logic [AW-1:0] head_reg;
    logic [AW-1:0] head_next;
    logic [CW-1:0] fill_reg;
    logic [CW-1:0] fill_next;
    logic          flipped_reg;
    logic          flipped_next;

    logic                             full;
    logic                             empty;
    logic [CW-1:0]                    fill_m1;
    logic [CW-1:0]                    half;
    logic [CW-1:0]                    half_m1;
    logic [CW+5:0]                    fill_ext;
    logic [deqr_pkg::STATUS_W-1:0]    status;
    logic                             pop;

    // slot of logical position p counted from head, forward or backward
    function automatic logic [AW-1:0] slot_at(
        input logic [AW-1:0] h,
        input logic          back,
        input logic [AW-1:0] p
    );
        logic [AW:0] sum;
        logic [AW:0] dif;
        sum = {1'b0, h} + {1'b0, p};
        if (sum >= (AW+1)'(DEPTH))
        begin
            sum = sum - (AW+1)'(DEPTH);
        end
        dif = {1'b0, h} + (AW+1)'(DEPTH) - {1'b0, p};
        if (dif >= (AW+1)'(DEPTH))
        begin
            dif = dif - (AW+1)'(DEPTH);
        end
        slot_at = back ? dif[AW-1:0] : sum[AW-1:0];
    endfunction

    assign full    = (fill_reg == CW'(DEPTH));
    assign empty   = (fill_reg == '0);
    assign fill_m1 = fill_reg - 1'b1;

    // operation decode and next pointer state
    always_comb
    begin
        head_next    = head_reg;
        fill_next    = fill_reg;
        flipped_next = flipped_reg;
        status       = deqr_pkg::ST_OK;
        pop          = 1'b0;
        we           = 1'b0;
        waddr        = head_reg;
        raddr_pop    = head_reg;
        case (kind)
            deqr_pkg::OP_PUSH_BACK:
            begin
                if (full)
                begin
                    status = deqr_pkg::ST_FULL;
                end
                else
                begin
                    we        = 1'b1;
                    waddr     = slot_at(head_reg, flipped_reg, fill_reg[AW-1:0]);
                    fill_next = fill_reg + 1'b1;
                end
            end
            deqr_pkg::OP_PUSH_FRONT:
            begin
                if (full)
                begin
                    status = deqr_pkg::ST_FULL;
                end
                else
                begin
                    head_next = slot_at(head_reg, !flipped_reg, AW'(1));
                    we        = 1'b1;
                    waddr     = head_next;
                    fill_next = fill_reg + 1'b1;
                end
            end
            deqr_pkg::OP_POP_FRONT:
            begin
                if (empty)
                begin
                    status = deqr_pkg::ST_EMPTY;
                end
                else
                begin
                    pop       = 1'b1;
                    raddr_pop = head_reg;
                    head_next = slot_at(head_reg, flipped_reg, AW'(1));
                    fill_next = fill_m1;
                end
            end
            deqr_pkg::OP_POP_BACK:
            begin
                if (empty)
                begin
                    status = deqr_pkg::ST_EMPTY;
                end
                else
                begin
                    pop       = 1'b1;
                    raddr_pop = slot_at(head_reg, flipped_reg, fill_m1[AW-1:0]);
                    fill_next = fill_m1;
                end
            end
            deqr_pkg::OP_REVERSE:
            begin
                if (empty)
                begin
                    status = deqr_pkg::ST_EMPTY;
                end
                else
                begin
                    head_next    = slot_at(head_reg, flipped_reg, fill_m1[AW-1:0]);
                    flipped_next = !flipped_reg;
                end
            end
            default:
            begin
                status = deqr_pkg::ST_OK;
            end
        endcase
    end

    // middle element addresses of the contents after the operation
    assign half     = fill_next >> 1;
    assign half_m1  = half - 1'b1;
    assign raddr_mr = slot_at(head_next, flipped_next, half[AW-1:0]);
    assign raddr_ml = slot_at(head_next, flipped_next, half_m1[AW-1:0]);
    assign fill_ext = (CW+6)'(fill_next);

    // metadata for the result stage, with bypass of this transaction's write
    always_comb
    begin
        meta.status    = status;
        meta.pop       = pop;
        meta.count     = fill_ext[5:0];
        meta.none_left = (fill_next == '0);
        meta.odd       = fill_next[0];
        meta.byp_ml    = we && (waddr == raddr_ml);
        meta.byp_mr    = we && (waddr == raddr_mr);
        meta.wdata     = data;
    end

    // pointer state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            fill_reg    <= '0;
            flipped_reg <= 1'b0;
        end
        else if (accept)
        begin
            head_reg    <= head_next;
            fill_reg    <= fill_next;
            flipped_reg <= flipped_next;
        end
    end

    `DEQR_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= CW'(DEPTH), "fill above depth")
    `DEQR_ASSERT_NEXT(a_push_grows, accept && kind == deqr_pkg::OP_PUSH_BACK && !full, fill_reg == $past(fill_reg) + 1'b1, "push back did not grow fill")
    `DEQR_ASSERT_NEXT(a_reverse_flips, accept && kind == deqr_pkg::OP_REVERSE && !empty, flipped_reg != $past(flipped_reg), "reverse did not toggle direction")
    `DEQR_ASSERT_NEXT(a_empty_pop_holds, accept && (kind == deqr_pkg::OP_POP_FRONT || kind == deqr_pkg::OP_POP_BACK) && empty, fill_reg == '0 && head_reg == $past(head_reg), "pop on empty changed state")

endmodule

>>> rtl/deqr_result.sv
// result register, output handshake and final field selection
module deqr_result (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 accept,
    input  deqr_pkg::meta_t                      meta_in,
    input  logic signed [deqr_pkg::DATA_W-1:0]   rd_pop,
    input  logic signed [deqr_pkg::DATA_W-1:0]   rd_ml,
    input  logic signed [deqr_pkg::DATA_W-1:0]   rd_mr,
    input  logic                                 out_ready,
    output logic                                 in_ready,
    output logic                                 out_valid,
    output logic [deqr_pkg::STATUS_W-1:0]        status,
    output logic signed [deqr_pkg::DATA_W-1:0]   popped,
    output logic [deqr_pkg::COUNT_W-1:0]         count,
    output logic signed [deqr_pkg::DATA_W-1:0]   middle_left,
    output logic signed [deqr_pkg::DATA_W-1:0]   middle_right
);

    deqr_pkg::meta_t                    meta_reg;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic signed [deqr_pkg::DATA_W-1:0] mr_word;
    logic signed [deqr_pkg::DATA_W-1:0] ml_word;

    // a new transaction may enter whenever the held result leaves or none is held
    assign in_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // metadata payload, held while the receiver stalls
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            meta_reg <= meta_in;
        end
    end

    // field selection from memory read data and bypassed write data
    assign mr_word = meta_reg.byp_mr ? meta_reg.wdata : rd_mr;
    assign ml_word = meta_reg.odd ? mr_word : (meta_reg.byp_ml ? meta_reg.wdata : rd_ml);

    assign out_valid    = out_valid_reg;
    assign status       = meta_reg.status;
    assign count        = meta_reg.count;
    assign popped       = meta_reg.pop ? rd_pop : '0;
    assign middle_right = meta_reg.none_left ? '0 : mr_word;
    assign middle_left  = meta_reg.none_left ? '0 : ml_word;

endmodule

>>> rtl/deque_with_reverse_and_middle_unit.sv
// Bounded double-ended queue of signed words with reverse and middle lookup.
// Input channel (in_valid/in_ready) carries kind and data: push back, push
// front, pop front, pop back or reverse. Output channel (out_valid/out_ready)
// returns one transaction per input: status, popped word, count after the
// operation and the two middle elements of the resulting contents.
// The result appears in the cycle after acceptance, taken from the
// registered read ports of the word storage.
// Throughput is one transaction per cycle while results are taken; each
// operation is a pointer update and at most one write plus three reads of three identical storage copies.
// Reverse moves no data, it repoints the front and flips the walk direction.
// Reset clears front pointer, count and direction and empties the output
// register; storage is not cleared and no clearing pass is needed.
// When the receiver stalls, the result is held and in_ready drops until the
// result is taken; a result and the next input may move in the same cycle.
module deque_with_reverse_and_middle_unit #(
    parameter int DEPTH = deqr_pkg::DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [deqr_pkg::KIND_W-1:0]         kind,
    input  logic signed [deqr_pkg::DATA_W-1:0]  data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [deqr_pkg::STATUS_W-1:0]       status,
    output logic signed [deqr_pkg::DATA_W-1:0]  popped,
    output logic [deqr_pkg::COUNT_W-1:0]        count,
    output logic signed [deqr_pkg::DATA_W-1:0]  middle_left,
    output logic signed [deqr_pkg::DATA_W-1:0]  middle_right
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic                               accept;
    logic                               we;
    logic [AW-1:0]                      waddr;
    logic [AW-1:0]                      raddr_pop;
    logic [AW-1:0]                      raddr_ml;
    logic [AW-1:0]                      raddr_mr;
    logic signed [deqr_pkg::DATA_W-1:0] rd_pop;
    logic signed [deqr_pkg::DATA_W-1:0] rd_ml;
    logic signed [deqr_pkg::DATA_W-1:0] rd_mr;
    deqr_pkg::meta_t                    meta;
    logic                               wr_en;

    assign accept = in_valid && in_ready;
    assign wr_en  = accept && we;

    // pointer state and address generation
    deqr_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .kind      (kind),
        .data      (data),
        .we        (we),
        .waddr     (waddr),
        .raddr_pop (raddr_pop),
        .raddr_ml  (raddr_ml),
        .raddr_mr  (raddr_mr),
        .meta      (meta)
    );

    // three identical storage copies, one per read address
    deqr_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram_pop (
        .clk   (clk),
        .we    (wr_en),
        .waddr (waddr),
        .wdata (data),
        .re    (accept),
        .raddr (raddr_pop),
        .rdata (rd_pop)
    );

    deqr_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram_ml (
        .clk   (clk),
        .we    (wr_en),
        .waddr (waddr),
        .wdata (data),
        .re    (accept),
        .raddr (raddr_ml),
        .rdata (rd_ml)
    );

    deqr_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram_mr (
        .clk   (clk),
        .we    (wr_en),
        .waddr (waddr),
        .wdata (data),
        .re    (accept),
        .raddr (raddr_mr),
        .rdata (rd_mr)
    );

    // result register and output handshake
    deqr_result u_result (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .meta_in      (meta),
        .rd_pop       (rd_pop),
        .rd_ml        (rd_ml),
        .rd_mr        (rd_mr),
        .out_ready    (out_ready),
        .in_ready     (in_ready),
        .out_valid    (out_valid),
        .status       (status),
        .popped       (popped),
        .count        (count),
        .middle_left  (middle_left),
        .middle_right (middle_right)
    );

endmodule

>>> tb/deque_result_checker.sv
// checker for the deque: watches both channels, predicts each result and compares it
module deque_result_checker
    import deqr_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [KIND_W-1:0]          kind,
    input  logic signed [DATA_W-1:0]   data,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [STATUS_W-1:0]        status,
    input  logic signed [DATA_W-1:0]   popped,
    input  logic [COUNT_W-1:0]         count,
    input  logic signed [DATA_W-1:0]   middle_left,
    input  logic signed [DATA_W-1:0]   middle_right,
    output int                         fail_count,
    output int                         outstanding
);

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] popped;
        logic [COUNT_W-1:0]       count;
        logic signed [DATA_W-1:0] middle_left;
        logic signed [DATA_W-1:0] middle_right;
    } deque_result_t;

    // shadow copy of the deque contents and pointers
    logic signed [DATA_W-1:0] shadow_words [DEPTH];
    int                       front_slot = 0;
    int                       held = 0;
    logic                     walk_reversed = 1'b0;

    deque_result_t            awaited_results [$];
    int                       mismatches = 0;

    assign fail_count = mismatches;

    // physical slot of logical position pos, walking from the front
    function automatic int slot_at(input int pos);
        int p;
        p = pos % DEPTH;
        if (walk_reversed)
            return (front_slot + DEPTH - p) % DEPTH;
        return (front_slot + p) % DEPTH;
    endfunction

    // apply one operation to the shadow deque and return the result it yields
    function automatic deque_result_t deque_step(input logic [KIND_W-1:0] op,
                                                 input logic signed [DATA_W-1:0] word);
        deque_result_t res;
        int            half;
        res = '0;
        res.status = ST_OK;
        case (op)
            OP_PUSH_BACK:
            begin
                if (held >= DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    shadow_words[slot_at(held)] = word;
                    held++;
                end
            end
            OP_PUSH_FRONT:
            begin
                if (held >= DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    front_slot = walk_reversed ? (front_slot + 1) % DEPTH
                                               : (front_slot + DEPTH - 1) % DEPTH;
                    shadow_words[front_slot] = word;
                    held++;
                end
            end
            OP_POP_FRONT:
            begin
                if (held == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    res.popped = shadow_words[front_slot];
                    front_slot = walk_reversed ? (front_slot + DEPTH - 1) % DEPTH
                                               : (front_slot + 1) % DEPTH;
                    held--;
                end
            end
            OP_POP_BACK:
            begin
                if (held == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    res.popped = shadow_words[slot_at(held - 1)];
                    held--;
                end
            end
            OP_REVERSE:
            begin
                if (held == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    front_slot = slot_at(held - 1);
                    walk_reversed = ~walk_reversed;
                end
            end
            default:
            begin
                // unused codes leave everything as it is
            end
        endcase

        // middle lookup on the resulting contents
        if (held != 0)
        begin
            half = held / 2;
            res.middle_right = shadow_words[slot_at(half)];
            res.middle_left  = (held % 2 == 1) ? res.middle_right
                                               : shadow_words[slot_at(half - 1)];
        end
        res.count = held[COUNT_W-1:0];
        return res;
    endfunction

    task automatic compare_field(input string field, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
            mismatches++;
        end
    endtask

    // score outgoing transactions, then predict incoming ones
    always @(posedge clk or negedge rst_n)
    begin
        deque_result_t want;
        if (!rst_n)
        begin
            front_slot    = 0;
            held          = 0;
            walk_reversed = 1'b0;
            awaited_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got status %h count %h",
                             $time, status, count);
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    compare_field("status", DATA_W'(want.status), DATA_W'(status));
                    compare_field("popped", want.popped, popped);
                    compare_field("count", DATA_W'(want.count), DATA_W'(count));
                    compare_field("middle_left", want.middle_left, middle_left);
                    compare_field("middle_right", want.middle_right, middle_right);
                end
            end
            if (in_valid && in_ready)
                awaited_results.push_back(deque_step(kind, data));
            outstanding <= awaited_results.size();
        end
    end

endmodule

>>> tb/deque_with_reverse_and_middle_unit_tb.sv
// testbench top for the deque: clock, reset, stimulus, receiver stalls and verdict
module deque_with_reverse_and_middle_unit_tb;
    import deqr_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1530;
    localparam int DRAIN_EVERY  = 400;
    localparam int IDLE_LIMIT   = 1000;
    localparam int TAIL_CYCLES  = 8;

    // codes the block does not use
    localparam logic [KIND_W-1:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] OP_UNUSED_MID   = 3'd6;
    localparam logic [KIND_W-1:0] OP_UNUSED_LAST  = 3'd7;

    localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [KIND_W-1:0]        kind = '0;
    logic signed [DATA_W-1:0] data = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] popped;
    logic [COUNT_W-1:0]       count;
    logic signed [DATA_W-1:0] middle_left;
    logic signed [DATA_W-1:0] middle_right;

    int                       fail_count;
    int                       outstanding;
    int                       idle_cycles = 0;
    bit                       tx_calm = 1'b0;
    bit                       rx_calm = 1'b0;

    deque_with_reverse_and_middle_unit #(
        .DEPTH (DEPTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .data         (data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .popped       (popped),
        .count        (count),
        .middle_left  (middle_left),
        .middle_right (middle_right)
    );

    deque_result_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .data         (data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .popped       (popped),
        .count        (count),
        .middle_left  (middle_left),
        .middle_right (middle_right),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned pick_gap(input bit calm);
        if (calm)
            return 0;
        return $urandom_range(0, 14);
    endfunction

    // mostly random words, now and then an extreme
    function automatic logic signed [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 19))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return '0;
            3:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // operation mix of unused codes, reverses, and pushes or pops weighted by push_pct
    function automatic logic [KIND_W-1:0] pick_kind(input int push_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            return KIND_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
        if (roll < 12)
            return OP_REVERSE;
        if ($urandom_range(0, 99) < push_pct)
            return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
    endfunction

    // offer one transaction after a random gap and hold it until accepted
    task automatic send_item(input logic [KIND_W-1:0] op,
                             input logic signed [DATA_W-1:0] word);
        int unsigned gap;
        gap = pick_gap(tx_calm);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= op;
        data     <= word;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
    endtask

    // stop sending until every predicted result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // receiver: random stall before each result, with calm stretches
    initial
    begin
        int unsigned stall;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = pick_gap(rx_calm);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
            if ($urandom_range(0, 39) == 0)
                rx_calm = ~rx_calm;
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // reset, directed items, random phases, verdict
    initial
    begin
        int sent_random;
        int phase_len;
        int push_pct;
        int k;
        sent_random = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty deque refusals and unused codes
        send_item(OP_POP_FRONT, pick_word());
        send_item(OP_POP_BACK, pick_word());
        send_item(OP_REVERSE, pick_word());
        send_item(OP_UNUSED_FIRST, WORD_MAX);
        // single element, reverse on it
        send_item(OP_PUSH_BACK, WORD_MAX);
        send_item(OP_REVERSE, '0);
        send_item(OP_PUSH_FRONT, WORD_MIN);
        send_item(OP_PUSH_BACK, '0);
        send_item(OP_PUSH_BACK, '1);
        send_item(OP_UNUSED_MID, WORD_MIN);
        send_item(OP_REVERSE, '1);
        send_item(OP_PUSH_FRONT, 32'sh5555_5555);
        send_item(OP_PUSH_BACK, 32'shaaaa_aaaa);
        send_item(OP_POP_BACK, '0);
        send_item(OP_POP_FRONT, '0);
        send_item(OP_UNUSED_LAST, '1);
        send_item(OP_REVERSE, '0);
        send_item(OP_POP_FRONT, '0);
        send_item(OP_POP_BACK, '0);
        send_item(OP_POP_FRONT, '0);
        // back to empty
        send_item(OP_POP_BACK, '0);
        send_item(OP_POP_FRONT, '0);
        drain_results();

        // random phases that fill, drain or mix, so full and empty are reached often
        while (sent_random < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 2))
                0:       push_pct = 85;
                1:       push_pct = 15;
                default: push_pct = 50;
            endcase
            phase_len = $urandom_range(20, 90);
            tx_calm = ($urandom_range(0, 3) == 0);
            for (k = 0; k < phase_len && sent_random < RANDOM_ITEMS; k++)
            begin
                send_item(pick_kind(push_pct), pick_word());
                sent_random++;
                if (sent_random % DRAIN_EVERY == 0)
                    drain_results();
            end
        end

        // wait for the last results, then a few quiet cycles
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> deque_with_reverse_and_middle_unit.f
+incdir+rtl
rtl/deqr_pkg.sv
rtl/deqr_ram.sv
rtl/deqr_ctrl.sv
rtl/deqr_result.sv
rtl/deque_with_reverse_and_middle_unit.sv
tb/deque_result_checker.sv
tb/deque_with_reverse_and_middle_unit_tb.sv
